// File: rtl/omp_pkg.sv
// Shared types, codes and constants for the operating mode policy block.
package omp_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [2:0]  decision_t;
  typedef logic [1:0]  phase_t;
  typedef logic [1:0]  finish_t;
  typedef logic [3:0]  event_t;
  typedef logic [5:0]  effect_t;
  typedef logic [16:0] secs_t;
  typedef logic [31:0] msec_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [16:0] cfg_data_t;

  // Operating modes
  localparam mode_t MODE_NORMAL  = 2'd0;
  localparam mode_t MODE_FEEDING = 2'd1;
  localparam mode_t MODE_WATER   = 2'd2;
  localparam mode_t MODE_MAINT   = 2'd3;

  // Decisions
  localparam decision_t DEC_NO_CHANGE   = 3'd0;
  localparam decision_t DEC_ACCEPTED    = 3'd1;
  localparam decision_t DEC_REMAIN_UPD  = 3'd2;
  localparam decision_t DEC_INVALID_CFG = 3'd3;
  localparam decision_t DEC_INVALID_CMD = 3'd4;

  // Effect phases
  localparam phase_t PHASE_NONE  = 2'd0;
  localparam phase_t PHASE_ENTER = 2'd1;
  localparam phase_t PHASE_EXIT  = 2'd2;
  localparam phase_t PHASE_STAY  = 2'd3;

  // Finish reasons
  localparam finish_t FIN_NONE    = 2'd0;
  localparam finish_t FIN_MANUAL  = 2'd1;
  localparam finish_t FIN_TIMEOUT = 2'd2;

  // Event bits
  localparam event_t EV_SAVE     = 4'b0001;
  localparam event_t EV_CHANGED  = 4'b0010;
  localparam event_t EV_STARTED  = 4'b0100;
  localparam event_t EV_FINISHED = 4'b1000;

  // Configuration register indexes
  localparam cfg_idx_t CFG_FEED_DUR    = 2'd0;
  localparam cfg_idx_t CFG_RETURN_AUTO = 2'd1;
  localparam cfg_idx_t CFG_MODE_EFFECT = 2'd2;

  // Reset values of configuration
  localparam logic [2:0] RETURN_AUTO_RST = 3'b001;

  // floor(x / 1000) == (x * DIV_RECIP) >> DIV_SHIFT for any 32-bit x
  localparam logic [28:0] DIV_RECIP = 29'd274877907;
  localparam int          DIV_SHIFT = 38;

endpackage

// File: rtl/omp_if.sv
// Channel interfaces: mode item input, result output and configuration writes.
interface omp_in_if;
  import omp_pkg::*;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        from_local;
  logic [2:0]  requested_mode;
  msec_t       now_ms;

  modport source (output valid, cmd, from_local, requested_mode, now_ms, input ready);
  modport sink   (input valid, cmd, from_local, requested_mode, now_ms, output ready);
endinterface

interface omp_out_if;
  import omp_pkg::*;
  logic      valid;
  logic      ready;
  decision_t decision;
  mode_t     mode_after;
  secs_t     remaining_s;
  phase_t    effect_phase;
  finish_t   finish_reason;
  event_t    event_bits;
  effect_t   effect_bits;

  modport source (output valid, decision, mode_after, remaining_s, effect_phase,
                  finish_reason, event_bits, effect_bits, input ready);
  modport sink   (input valid, decision, mode_after, remaining_s, effect_phase,
                  finish_reason, event_bits, effect_bits, output ready);
endinterface

interface omp_cfg_if;
  import omp_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/operating_mode_policy.sv
// Top level of the operating mode policy block.
//
// Usage: each transaction on in_ch is a tick (cmd = 0) or a mode request
// (cmd = 1) stamped with now_ms. Every input transaction yields exactly one
// result transaction on out_ch with the decision, the mode and remaining
// feeding seconds after the item, the effect phase, finish reason, event
// bits and effect flags. Registers are written over cfg_ch (index 0 feeding
// duration, 1 return auto bits, 2 mode effect bits); cfg_ch is always ready
// and must only be written while no result is outstanding.
// Each result is registered as its input is accepted. Throughput: one item
// per cycle unless out_ch stalls; the path is one 32-bit subtract, one 32x29
// reciprocal multiply for the divide by 1000 and a 17-bit subtract.
// A single output register sits between the channels: in_ch is ready when
// it is empty or being drained, so a stalled receiver holds in_ch off after
// one buffered result, and nothing is dropped.
// Reset (synchronous, rst_n low): mode normal, start time 0, remaining 0,
// duration 0, return auto bits 3'b001, effect bits 0, output empty.
module operating_mode_policy
  import omp_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  omp_in_if.sink      in_ch,
  omp_out_if.source   out_ch,
  omp_cfg_if.sink     cfg_ch
);

  // Configuration registers
  secs_t        feed_dur_r;
  logic [26:0]  feed_ms_r;
  logic [2:0]   ret_auto_r;
  logic [7:0]   mode_fx_r;

  // Policy state
  mode_t        mode_r, mode_nxt;
  msec_t        start_r, start_nxt;
  secs_t        rem_r, rem_nxt;

  // Output register
  logic         out_valid_r, out_valid_nxt;
  decision_t    dec_r, dec_nxt;
  phase_t       phase_r, phase_nxt;
  finish_t      fin_r, fin_nxt;
  event_t       ev_r, ev_nxt;
  effect_t      fx_r, fx_nxt;

  logic         in_fire;
  logic         cfg_fire;
  logic         go_norm;
  finish_t      go_reason;
  msec_t        diff;
  logic [60:0]  prod;
  logic [22:0]  elapsed_s;
  secs_t        rem_calc;
  logic         timed_out;
  logic [26:0]  wr_ms;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Duration in ms for the timeout compare: d*1000 = d*1024 - d*16 - d*8
  assign wr_ms = (27'(cfg_ch.data) << 10) - (27'(cfg_ch.data) << 4)
               - (27'(cfg_ch.data) << 3);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_dur_r <= '0;
      feed_ms_r  <= '0;
      ret_auto_r <= RETURN_AUTO_RST;
      mode_fx_r  <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        CFG_FEED_DUR: begin
          feed_dur_r <= cfg_ch.data;
          feed_ms_r  <= wr_ms;
        end
        CFG_RETURN_AUTO: ret_auto_r <= cfg_ch.data[2:0];
        CFG_MODE_EFFECT: mode_fx_r  <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Elapsed whole seconds since mode start, no wrap
  assign diff      = (in_ch.now_ms > start_r) ? (in_ch.now_ms - start_r) : '0;
  assign prod      = 61'(diff) * 61'(DIV_RECIP);
  assign elapsed_s = prod[DIV_SHIFT +: 23];
  assign timed_out = diff >= {5'b0, feed_ms_r};
  // Only used when not timed out, so elapsed_s < duration fits 17 bits
  assign rem_calc  = feed_dur_r - elapsed_s[16:0];

  // Policy decision for the item on in_ch
  always_comb begin
    dec_nxt   = DEC_NO_CHANGE;
    phase_nxt = PHASE_NONE;
    fin_nxt   = FIN_NONE;
    ev_nxt    = '0;
    fx_nxt    = '0;
    mode_nxt  = mode_r;
    start_nxt = start_r;
    rem_nxt   = rem_r;
    go_norm   = 1'b0;
    go_reason = FIN_NONE;

    if (in_ch.cmd) begin
      // requested_mode bit 2 set means a code above maintenance
      if (!in_ch.from_local || in_ch.requested_mode[2]) begin
        dec_nxt = DEC_INVALID_CMD;
      end else if (in_ch.requested_mode[1:0] == mode_r) begin
        dec_nxt = DEC_NO_CHANGE;
      end else if (in_ch.requested_mode[1:0] == MODE_NORMAL) begin
        go_norm   = 1'b1;
        go_reason = FIN_MANUAL;
      end else begin
        dec_nxt   = DEC_ACCEPTED;
        phase_nxt = PHASE_ENTER;
        ev_nxt    = EV_SAVE | EV_CHANGED | EV_STARTED
                  | ((mode_r != MODE_NORMAL) ? EV_FINISHED : '0);
        mode_nxt  = in_ch.requested_mode[1:0];
        start_nxt = in_ch.now_ms;
        rem_nxt   = '0;
        unique case (in_ch.requested_mode[1:0])
          MODE_FEEDING: begin
            fx_nxt  = {mode_fx_r[2], mode_fx_r[2], 3'b000, mode_fx_r[1]};
            rem_nxt = feed_dur_r;
            if (feed_dur_r == '0 || !ret_auto_r[0]) begin
              dec_nxt = DEC_INVALID_CFG;
            end
          end
          MODE_WATER: begin
            fx_nxt = {mode_fx_r[5], mode_fx_r[5], 2'b00, mode_fx_r[4], mode_fx_r[3]};
            if (ret_auto_r[1]) begin
              dec_nxt = DEC_INVALID_CFG;
            end
          end
          default: begin
            fx_nxt = {mode_fx_r[6] & mode_fx_r[7], mode_fx_r[6], 1'b1, 3'b000};
            if (ret_auto_r[2]) begin
              dec_nxt = DEC_INVALID_CFG;
            end
          end
        endcase
        // Rejected entry leaves everything as it was
        if (dec_nxt == DEC_INVALID_CFG) begin
          phase_nxt = PHASE_NONE;
          ev_nxt    = '0;
          fx_nxt    = '0;
          mode_nxt  = mode_r;
          start_nxt = start_r;
          rem_nxt   = rem_r;
        end
      end
    end else if (mode_r == MODE_FEEDING) begin
      // Tick while feeding
      if (feed_dur_r == '0) begin
        dec_nxt = DEC_INVALID_CFG;
      end else if (timed_out) begin
        go_norm   = 1'b1;
        go_reason = FIN_TIMEOUT;
      end else if (rem_calc != rem_r) begin
        rem_nxt   = rem_calc;
        dec_nxt   = DEC_REMAIN_UPD;
        phase_nxt = PHASE_STAY;
      end
    end

    // Return to normal; previous mode is never normal here
    if (go_norm) begin
      dec_nxt   = DEC_ACCEPTED;
      phase_nxt = PHASE_EXIT;
      fin_nxt   = go_reason;
      ev_nxt    = EV_SAVE | EV_CHANGED | EV_FINISHED;
      fx_nxt    = {1'b0, mode_fx_r[0], 1'b0, mode_fx_r[0], 2'b00};
      mode_nxt  = MODE_NORMAL;
      start_nxt = in_ch.now_ms;
      rem_nxt   = '0;
    end
  end

  assign out_valid_nxt = in_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // State and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      start_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        mode_r  <= mode_nxt;
        start_r <= start_nxt;
        rem_r   <= rem_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dec_r   <= dec_nxt;
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
      ev_r    <= ev_nxt;
      fx_r    <= fx_nxt;
    end
  end

  // Mode and remaining after the item are the live state registers
  assign out_ch.valid         = out_valid_r;
  assign out_ch.decision      = dec_r;
  assign out_ch.mode_after    = mode_r;
  assign out_ch.remaining_s   = rem_r;
  assign out_ch.effect_phase  = phase_r;
  assign out_ch.finish_reason = fin_r;
  assign out_ch.event_bits    = ev_r;
  assign out_ch.effect_bits   = fx_r;

  // Remaining time is only nonzero while feeding
  a_rem_only_feeding: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_FEEDING |-> rem_r == '0)
    else $error("remaining time nonzero outside feeding");

  // Every accepted item produces a pending result
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  // Invalid commands never touch state
  a_invalid_cmd_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.cmd && (!in_ch.from_local || in_ch.requested_mode[2])
    |=> $stable(mode_r) && $stable(start_r) && $stable(rem_r))
    else $error("invalid command changed state");

  // A timeout result always lands in normal mode
  a_timeout_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fin_r == FIN_TIMEOUT |-> mode_r == MODE_NORMAL && rem_r == '0)
    else $error("timeout result not in normal mode");

  // Remaining updates only occur while feeding
  a_update_feeding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dec_r == DEC_REMAIN_UPD |-> mode_r == MODE_FEEDING)
    else $error("remaining update outside feeding");

endmodule
